/* sv/fpa_pkg.sv */
// Package for the fixed-point ALU: command and status codes, default widths.
// No dependencies; used by fixed_point_alu.
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int WORD_W        = 32;
  localparam int CMD_W         = 4;
  localparam int STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_INT_TO_FP = 4'd0;
  localparam logic [CMD_W-1:0] CMD_TRUNC     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ROUND     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ADD       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SUB       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ADD_INT   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SUB_INT   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MUL       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MUL_INT   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DIV       = 4'd9;
  localparam logic [CMD_W-1:0] CMD_DIV_INT   = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

endpackage

/* sv/fixed_point_alu.sv */
// Pipelined signed fixed-point ALU (scale 2^FRAC_BITS) with a bit-per-stage divider.
// Depends on fpa_pkg for codes and default widths.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+-------------------------------
//  in      | in_command, in_operand_a, in_operand_b     | taken when start & !busy
//  out     | out_result, out_status                     | out_valid strobe, one cycle
//
// One word enters every cycle; busy is always low. Every command goes through
// the same pipe: input capture, stage 1, the restoring divider chain (one
// quotient bit per stage) and the output register.
// Reset (synchronous, rst_n low) clears the valid bits only.
// The receiver cannot stall; results leave in the order words came in.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpa_pkg::CMD_W-1:0]     in_command,
  input  logic signed [fpa_pkg::WORD_W-1:0] in_operand_a,
  input  logic signed [fpa_pkg::WORD_W-1:0] in_operand_b,
  output logic                          out_valid,
  output logic signed [fpa_pkg::WORD_W-1:0] out_result,
  output logic [fpa_pkg::STATUS_W-1:0]  out_status
);

  localparam int NW = fpa_pkg::WORD_W + FRAC_BITS;  // dividend / quotient width
  localparam logic [32:0] HALF    = 33'(1) << (FRAC_BITS - 1);
  localparam logic signed [63:0] SCALE_M1 = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  assign busy = 1'b0;

  // stage 0: input capture
  logic        v0_r;
  logic [3:0]  cmd0_r;
  logic signed [31:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    cmd0_r <= in_command;
    a0_r   <= in_operand_a;
    b0_r   <= in_operand_b;
  end

  // stage 1: multiply, simple ops, divider operand prep
  logic        v1_r;
  logic [3:0]  cmd1_r;
  logic signed [63:0] prod1_r, wide1_r;
  logic [NW-1:0] num1_r;
  logic [31:0] dvs1_r;
  logic        neg1_r, dz1_r;

  logic signed [63:0] wide1_nxt, a_ext, b_ext, b_sh;
  logic [31:0] mag_a, mag_b;
  logic [32:0] rnd_sum;
  logic [63:0] tr_mag, rd_mag;

  always_comb begin
    a_ext  = 64'(a0_r);
    b_ext  = 64'(b0_r);
    b_sh   = b_ext <<< FRAC_BITS;
    mag_a  = a0_r[31] ? (32'd0 - a0_r) : a0_r;
    mag_b  = b0_r[31] ? (32'd0 - b0_r) : b0_r;
    rnd_sum = {1'b0, mag_a} + HALF;
    tr_mag = 64'(mag_a >> FRAC_BITS);
    rd_mag = 64'(rnd_sum >> FRAC_BITS);
    case (cmd0_r)
      fpa_pkg::CMD_INT_TO_FP: wide1_nxt = b_sh;
      fpa_pkg::CMD_TRUNC:     wide1_nxt = a0_r[31] ? -$signed(tr_mag) : $signed(tr_mag);
      fpa_pkg::CMD_ROUND:     wide1_nxt = a0_r[31] ? -$signed(rd_mag) : $signed(rd_mag);
      fpa_pkg::CMD_ADD:       wide1_nxt = a_ext + b_ext;
      fpa_pkg::CMD_SUB:       wide1_nxt = a_ext - b_ext;
      fpa_pkg::CMD_ADD_INT:   wide1_nxt = a_ext + b_sh;
      fpa_pkg::CMD_SUB_INT:   wide1_nxt = a_ext - b_sh;
      default:                wide1_nxt = 64'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    cmd1_r  <= cmd0_r;
    prod1_r <= a_ext * b_ext;
    wide1_r <= wide1_nxt;
    num1_r  <= (cmd0_r == fpa_pkg::CMD_DIV) ? (NW'(mag_a) << FRAC_BITS) : NW'(mag_a);
    dvs1_r  <= mag_b;
    neg1_r  <= a0_r[31] ^ b0_r[31];
    dz1_r   <= (b0_r == 32'sd0);
  end

  // mul fixup into the side word as it enters the divider chain
  logic signed [63:0] wide_c0, prod_adj;
  always_comb begin
    prod_adj = prod1_r + (prod1_r[63] ? SCALE_M1 : 64'sd0);
    case (cmd1_r)
      fpa_pkg::CMD_MUL:     wide_c0 = prod_adj >>> FRAC_BITS;
      fpa_pkg::CMD_MUL_INT: wide_c0 = prod1_r;
      default:              wide_c0 = wide1_r;
    endcase
  end

  // divider chain, stages 1..NW, one quotient bit each
  logic          dv_r   [1:NW];
  logic [3:0]    dcmd_r [1:NW];
  logic signed [63:0] dwide_r [1:NW];
  logic [31:0]   rem_r  [1:NW];
  logic [NW-1:0] num_r  [1:NW];
  logic [NW-1:0] quo_r  [1:NW];
  logic [31:0]   dvs_r  [1:NW];
  logic          neg_r  [1:NW];
  logic          dz_r   [1:NW];

  for (genvar j = 1; j <= NW; j++) begin : g_div
    logic          v_in;
    logic [3:0]    cmd_in;
    logic signed [63:0] wide_in;
    logic [31:0]   rem_in, dvs_in;
    logic [NW-1:0] num_in, quo_in;
    logic          neg_in, dz_in;
    logic [32:0]   shifted, diff;
    logic          qbit;

    if (j == 1) begin : g_first
      assign v_in    = v1_r;
      assign cmd_in  = cmd1_r;
      assign wide_in = wide_c0;
      assign rem_in  = 32'd0;
      assign num_in  = num1_r;
      assign quo_in  = '0;
      assign dvs_in  = dvs1_r;
      assign neg_in  = neg1_r;
      assign dz_in   = dz1_r;
    end else begin : g_next
      assign v_in    = dv_r[j-1];
      assign cmd_in  = dcmd_r[j-1];
      assign wide_in = dwide_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign num_in  = num_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign dvs_in  = dvs_r[j-1];
      assign neg_in  = neg_r[j-1];
      assign dz_in   = dz_r[j-1];
    end

    assign shifted = {rem_in, num_in[NW-1]};
    assign diff    = shifted - {1'b0, dvs_in};
    assign qbit    = (shifted >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else begin
        dv_r[j] <= v_in;
      end
      dcmd_r[j]  <= cmd_in;
      dwide_r[j] <= wide_in;
      rem_r[j]   <= qbit ? diff[31:0] : shifted[31:0];
      num_r[j]   <= num_in << 1;
      quo_r[j]   <= {quo_in[NW-2:0], qbit};
      dvs_r[j]   <= dvs_in;
      neg_r[j]   <= neg_in;
      dz_r[j]    <= dz_in;
    end
  end

  // output stage: select, wrap, flag
  logic [NW-1:0] q_f;
  logic          is_div, q_ovf, w_ovf;
  logic signed [31:0] res_nxt;
  logic [1:0]    st_nxt;

  always_comb begin
    q_f    = quo_r[NW];
    is_div = (dcmd_r[NW] == fpa_pkg::CMD_DIV) || (dcmd_r[NW] == fpa_pkg::CMD_DIV_INT);
    // negative quotient may reach 2^31, positive only 2^31-1
    q_ovf  = neg_r[NW] ? (q_f > NW'(33'h080000000)) : (q_f > NW'(33'h07FFFFFFF));
    w_ovf  = !((dwide_r[NW][63:31] == '0) || (dwide_r[NW][63:31] == '1));
    if (is_div) begin
      if (dz_r[NW]) begin
        res_nxt = 32'sd0;
        st_nxt  = fpa_pkg::ST_DIV0;
      end else begin
        res_nxt = neg_r[NW] ? (32'd0 - q_f[31:0]) : q_f[31:0];
        st_nxt  = q_ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
      end
    end else begin
      res_nxt = dwide_r[NW][31:0];
      st_nxt  = w_ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
    end
  end

  logic        out_valid_r;
  logic signed [31:0] out_result_r;
  logic [1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[NW];
    end
    out_result_r <= res_nxt;
    out_status_r <= st_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

endmodule
